[rtl/olad_pkg.sv]
package olad_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int WORD_W     = 32;
    localparam int ECNT_W     = 5;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef enum logic [2:0] {
        ST_APPENDED  = 3'd0,
        ST_DELETED   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef enum logic {
        REQ_APPEND = 1'b0,
        REQ_DELETE = 1'b1
    } t_req_type;

    typedef struct packed {
        logic load;
        logic shift;
        logic cmp;
        logic valid;
    } t_cell_ctl;

    function automatic logic [ECNT_W-1:0] fn_ecnt(input t_cnt cnt);
        logic [CNT_W+ECNT_W-1:0] wide;
        wide = {{ECNT_W{1'b0}}, cnt};
        return wide[ECNT_W-1:0];
    endfunction

endpackage

[rtl/olad_req_if.sv]
interface olad_req_if;
    import olad_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic signed [31:0]    item_value;

    modport source (output valid, output req_type, output item_value, input ready);
    modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

[rtl/olad_rsp_if.sv]
interface olad_rsp_if;
    import olad_pkg::*;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [4:0]  entry_count;

    modport source (output valid, output status, output entry_count, input ready);
    modport sink   (input valid, input status, input entry_count, output ready);
endinterface

[rtl/olad_cell.sv]
module olad_cell import olad_pkg::*; (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_word     i_din,
    input  t_word     i_nbr,
    output t_word     o_val,
    output logic      o_hit
);

    t_word r_val;
    logic  r_hit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_val <= i_din;
        end else if (i_ctl.shift) begin
            r_val <= i_nbr;
        end
        if (i_ctl.cmp) begin
            r_hit <= i_ctl.valid && (r_val == i_din);
        end
    end

    assign o_val = r_val;
    assign o_hit = r_hit;

endmodule

[rtl/ordered_list_append_delete_key.sv]
// Append: the result register is loaded straight from the accept cycle.
// Delete steps: accept, compare in every cell, shift of later cells one place forward.
// Empty-list delete and full-list append also answer straight from the accept cycle.
// One request in flight; the next is taken once the result register can take a new result.
// Synchronous active-low reset empties the list; cell contents are not cleared.
module ordered_list_append_delete_key import olad_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    olad_req_if.sink     i_req,
    olad_rsp_if.source   o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SRCH  = 3'b010,
        S_SHIFT = 3'b100
    } t_state;

    t_state    r_state, n_state;
    t_cnt      r_count, n_count;
    t_word     r_key;
    logic      r_ovalid, n_ovalid;
    t_status   r_status, n_status;
    logic [ECNT_W-1:0] r_ecnt, n_ecnt;

    logic      out_free, acc, found;
    t_word     din;
    t_word     vals [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] hit, pfx;
    t_cell_ctl ctl  [LIST_DEPTH];

    assign out_free = !r_ovalid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && out_free;
    assign acc = i_req.valid && i_req.ready;
    assign din = (r_state == S_IDLE) ? t_word'(i_req.item_value) : r_key;
    assign found = |hit;

    genvar gi;
    generate
        for (gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
            localparam logic [LIST_DEPTH-1:0] LowMask = {LIST_DEPTH{1'b1}} >> (LIST_DEPTH-1-gi);
            assign pfx[gi] = |(hit & LowMask);

            always_comb begin
                ctl[gi].load  = acc && (i_req.req_type == REQ_APPEND)
                                && (r_count == t_cnt'(gi));
                ctl[gi].shift = (r_state == S_SHIFT) && out_free && found && pfx[gi];
                ctl[gi].cmp   = (r_state == S_SRCH);
                ctl[gi].valid = t_cnt'(gi) < r_count;
            end

            olad_cell u_cell (
                .i_clk (i_clk),
                .i_ctl (ctl[gi]),
                .i_din (din),
                .i_nbr ((gi == LIST_DEPTH-1) ? vals[gi] : vals[(gi+1) % LIST_DEPTH]),
                .o_val (vals[gi]),
                .o_hit (hit[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ovalid = r_ovalid && !o_rsp.ready;
        n_status = r_status;
        n_ecnt   = r_ecnt;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (i_req.req_type == REQ_APPEND) begin
                        n_ovalid = 1'b1;
                        if (r_count == t_cnt'(LIST_DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            n_status = ST_APPENDED;
                            n_count  = r_count + 1'b1;
                        end
                        n_ecnt = fn_ecnt(n_count);
                    end else if (r_count == '0) begin
                        n_ovalid = 1'b1;
                        n_status = ST_EMPTY;
                        n_ecnt   = fn_ecnt(r_count);
                    end else begin
                        n_state = S_SRCH;
                    end
                end
            end
            S_SRCH: begin
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                if (out_free) begin
                    n_state  = S_IDLE;
                    n_ovalid = 1'b1;
                    if (found) begin
                        n_status = ST_DELETED;
                        n_count  = r_count - 1'b1;
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                    n_ecnt = fn_ecnt(n_count);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
        r_status <= n_status;
        r_ecnt   <= n_ecnt;
        if (acc) begin
            r_key <= t_word'(i_req.item_value);
        end
    end

    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.status      = r_status;
    assign o_rsp.entry_count = r_ecnt;

    a_count_range: assert property (@(posedge i_clk) disable iff (i_rst_n !== 1'b1)
        r_count <= t_cnt'(LIST_DEPTH))
        else $error("entry count above list depth");

    a_srch_to_shift: assert property (@(posedge i_clk) disable iff (i_rst_n !== 1'b1)
        r_state == S_SRCH |=> r_state == S_SHIFT)
        else $error("compare cycle not followed by shift");

    a_delete_starts: assert property (@(posedge i_clk) disable iff (i_rst_n !== 1'b1)
        acc && (i_req.req_type == REQ_DELETE) && (r_count != '0) |=> r_state == S_SRCH)
        else $error("delete on non-empty list did not start search");

    a_hit_in_range: assert property (@(posedge i_clk) disable iff (i_rst_n !== 1'b1)
        r_state == S_SHIFT && found |-> r_count != '0)
        else $error("match reported in empty list");

endmodule
